>>> rtl/core/assert_macros.svh
// assertion macros for the lru core rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LRUPR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lru core check failed");
`define LRUPR_ASSERT_NEVER(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
    else $error("lru core forbidden condition seen");
`else
`define LRUPR_ASSERT(lbl, clk, rst, prop)
`define LRUPR_ASSERT_NEVER(lbl, clk, rst, prop)
`endif
`endif

>>> rtl/core/lrupr_pkg.sv
// shared constants, types and cell command structs for the lru core
// depends on nothing
package lrupr_pkg;

  localparam int PAGES   = 32;
  localparam int FRAMES  = 8;
  localparam int PAGE_W  = $clog2(PAGES);
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int RANK_W  = FRAME_W;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int CFG_W   = 4;
  localparam int MISS_W  = 32;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } state_t;

  // update broadcast to every cell
  typedef struct packed {
    logic   touch;
    logic   age_all;
    frame_t frame;
    rank_t  thr;
    logic   load;
    page_t  page;
  } cell_cmd_t;

  // search result handed from cell to cell along the row
  typedef struct packed {
    logic   hit_found;
    frame_t hit_frame;
    rank_t  hit_rank;
    logic   vic_found;
    frame_t vic_frame;
    rank_t  vic_rank;
    page_t  vic_page;
  } chain_t;

endpackage

>>> rtl/core/lrupr_cell.sv
// one frame slot: owner page, occupied flag and recency rank
// depends on lrupr_pkg
module lrupr_cell
  import lrupr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  frame_t    idx,
  input  page_t     lookup_page,
  input  rank_t     victim_rank,
  input  cell_cmd_t cmd,
  input  chain_t    chain_in,
  output chain_t    chain_out
);

  logic  valid;
  page_t owner;
  rank_t rank;

  logic match;
  logic is_victim;

  assign match     = valid && (owner == lookup_page);
  assign is_victim = valid && (rank == victim_rank);

  // first match along the row wins
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit_found && match) begin
      chain_out.hit_found = 1'b1;
      chain_out.hit_frame = idx;
      chain_out.hit_rank  = rank;
    end
    if (!chain_in.vic_found && is_victim) begin
      chain_out.vic_found = 1'b1;
      chain_out.vic_frame = idx;
      chain_out.vic_rank  = rank;
      chain_out.vic_page  = owner;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.touch) begin
      if (idx == cmd.frame) begin
        rank <= '0;
        if (cmd.load) begin
          valid <= 1'b1;
        end
      end else if (valid && (cmd.age_all || (rank < cmd.thr))) begin
        rank <= rank + rank_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.touch && cmd.load && (idx == cmd.frame)) begin
      owner <= cmd.page;
    end
  end

endmodule

>>> rtl/core/lrupr_row.sv
// row of frame cells with the search chain running through it
// depends on lrupr_pkg, lrupr_cell
module lrupr_row
  import lrupr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  page_t     lookup_page,
  input  rank_t     victim_rank,
  input  cell_cmd_t cmd,
  output chain_t    result
);

  chain_t link [FRAMES+1];

  assign link[0] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrupr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (frame_t'(i)),
      .lookup_page (lookup_page),
      .victim_rank (victim_rank),
      .cmd         (cmd),
      .chain_in    (link[i]),
      .chain_out   (link[i+1])
    );
  end

  assign result = link[FRAMES];

endmodule

>>> rtl/core/lru_page_replacement_core.sv
// lru page replacement core: one page access word in, one result word out
// done is registered from the update state, which follows the look state, and is high for one cycle
// one access at a time: each goes through the look then update pass over the cell row
// busy is low again in the cycle done is high, so the next access may start then
// reset (rst, synchronous, active high) empties every frame, clears miss count, limit = 8
// the receiver cannot stall: each result is held on the ports until the next result replaces it
module lru_page_replacement_core
  import lrupr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // access port
  input  logic              start,
  output logic              busy,
  input  logic [PAGE_W-1:0] page_number,
  // frame limit register
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // result port
  output logic              done,
  output logic              hit,
  output logic [FRAME_W-1:0] frame_number,
  output logic              evicted_valid,
  output logic [PAGE_W-1:0] evicted_page,
  output logic [MISS_W-1:0] miss_count
);

  `include "assert_macros.svh"

  state_t state, state_next;

  logic [CFG_W-1:0] frames_in_use;
  logic [CFG_W-1:0] limit;
  count_t           nff;          // frames filled so far, frames below it are occupied
  count_t           nff_m1;
  logic [MISS_W-1:0] fault_counter;

  page_t  page;                   // access word under work
  logic   hit_q;
  frame_t frame_q;
  logic   age_all_q;
  rank_t  thr_q;
  logic   fill_q;
  logic   ev_valid_q;
  page_t  ev_page_q;

  cell_cmd_t cmd;
  chain_t    srch;

  logic accept;
  logic fill_ok;

  assign accept = start && !busy;

  // limit clamp: zero acts as one, anything above the frame count as the frame count
  always_comb begin
    if (frames_in_use == '0) begin
      limit = CFG_W'(1);
    end else if (frames_in_use > CFG_W'(FRAMES)) begin
      limit = CFG_W'(FRAMES);
    end else begin
      limit = frames_in_use;
    end
  end

  assign fill_ok = CFG_W'(nff) < limit;
  // occupied ranks are always a permutation of 0..nff-1, so the lru frame holds nff-1
  assign nff_m1  = nff - count_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_W'(FRAMES);
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and the update broadcast to the cells
  always_comb begin
    state_next  = state;
    busy        = 1'b1;
    cmd         = '0;
    cmd.age_all = age_all_q;
    cmd.frame   = frame_q;
    cmd.thr     = thr_q;
    cmd.load    = !hit_q;
    cmd.page    = page;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.touch  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  lrupr_row u_row (
    .clk         (clk),
    .rst         (rst),
    .lookup_page (page),
    .victim_rank (nff_m1[RANK_W-1:0]),
    .cmd         (cmd),
    .result      (srch)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      page <= page_number;
    end
  end

  // look pass: decide hit, fill or evict from the row search
  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      hit_q      <= srch.hit_found;
      fill_q     <= 1'b0;
      ev_valid_q <= 1'b0;
      ev_page_q  <= '0;
      age_all_q  <= 1'b0;
      if (srch.hit_found) begin
        // hit promotes its frame: only frames more recent than it age
        frame_q <= srch.hit_frame;
        thr_q   <= srch.hit_rank;
      end else if (fill_ok) begin
        // next never used frame, every occupied frame ages
        frame_q   <= nff[FRAME_W-1:0];
        thr_q     <= '0;
        age_all_q <= 1'b1;
        fill_q    <= 1'b1;
      end else begin
        // reuse the least recently used frame
        frame_q    <= srch.vic_frame;
        thr_q      <= srch.vic_rank;
        ev_valid_q <= 1'b1;
        ev_page_q  <= srch.vic_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_counter <= '0;
    end else if ((state == ST_LOOK) && !srch.hit_found && (fault_counter != '1)) begin
      fault_counter <= fault_counter + MISS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nff <= '0;
    end else if ((state == ST_UPDATE) && fill_q) begin
      nff <= nff + count_t'(1);
    end
  end

  // result word, registered in the update state and held until the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      hit           <= hit_q;
      frame_number  <= frame_q;
      evicted_valid <= ev_valid_q;
      evicted_page  <= ev_page_q;
      miss_count    <= fault_counter;
    end
  end

  `LRUPR_ASSERT(a_update_then_done, clk, rst, (state == ST_UPDATE) |=> done)
  `LRUPR_ASSERT_NEVER(a_fill_overrun, clk, rst, nff > count_t'(FRAMES))
  `LRUPR_ASSERT(a_evict_only_on_miss, clk, rst, (done && evicted_valid) |-> !hit)

endmodule
